// File: rtl/ecd_pkg.sv
`default_nettype none
package ecd_pkg;

  localparam int unsigned EPOCH_W  = 40;
  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned DAYS_W   = 24;
  localparam int unsigned SOD_W    = 17;
  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned WDAY_W   = 3;

  localparam int unsigned SPLIT_STAGES = 8;
  localparam int unsigned CONV_STAGES  = 11;
  localparam int unsigned NUM_STAGES   = SPLIT_STAGES + CONV_STAGES;

  // calendar constants
  localparam longint unsigned ERA_DAYS      = 146097;
  localparam longint unsigned SHIFT_TO_ERA0 = 719468;
  localparam longint unsigned ERA_PAD       = 40;
  localparam longint unsigned YEARS_PER_ERA = 400;
  localparam longint unsigned DAYS_PER_YEAR = 365;
  localparam longint unsigned CENT_4Y       = 1460;
  localparam longint unsigned CENT_DAYS     = 36524;
  localparam longint unsigned SECS_PER_DAY  = 86400;
  localparam longint unsigned SECS_PER_MIN  = 60;
  localparam longint unsigned MINS_PER_HOUR = 60;

  // days offset so that every day count is positive and era aligned
  localparam longint unsigned DAY_BIAS  = SHIFT_TO_ERA0 + ERA_PAD * ERA_DAYS;
  localparam longint unsigned SEC_BIAS  = DAY_BIAS * SECS_PER_DAY;
  localparam longint unsigned YEAR_BIAS = ERA_PAD * YEARS_PER_ERA;
  // (days + 4) mod 7 == (biased days + 3) mod 7
  localparam longint unsigned WDAY_SHIFT = 3;

  // 86400 = 675 << 7
  localparam int unsigned     SOD_SH  = 7;
  localparam longint unsigned SOD_ODD = SECS_PER_DAY >> SOD_SH;

  // month from shifted day of year
  localparam longint unsigned MP_MUL = 5;
  localparam longint unsigned MP_ADD = 2;
  localparam longint unsigned MP_DIV = 153;

  // reciprocal shifts
  localparam int unsigned SH_675   = 32;
  localparam int unsigned SH_ERA   = 42;
  localparam int unsigned SH_1460  = 29;
  localparam int unsigned SH_36524 = 34;
  localparam int unsigned SH_365   = 27;
  localparam int unsigned SH_100   = 16;
  localparam int unsigned SH_153   = 19;
  localparam int unsigned SH_5     = 14;
  localparam int unsigned SH_15    = 19;
  localparam int unsigned SH_60    = 17;

  // ceil(2^S / d)
  localparam logic [22:0] RCP_675 =
    23'(((64'd1 << SH_675) + SOD_ODD - 64'd1) / SOD_ODD);
  localparam logic [24:0] RCP_ERA =
    25'(((64'd1 << SH_ERA) + ERA_DAYS - 64'd1) / ERA_DAYS);
  localparam logic [18:0] RCP_1460 =
    19'(((64'd1 << SH_1460) + CENT_4Y - 64'd1) / CENT_4Y);
  localparam logic [18:0] RCP_36524 =
    19'(((64'd1 << SH_36524) + CENT_DAYS - 64'd1) / CENT_DAYS);
  localparam logic [18:0] RCP_365 =
    19'(((64'd1 << SH_365) + DAYS_PER_YEAR - 64'd1) / DAYS_PER_YEAR);
  localparam logic [9:0] RCP_100 =
    10'(((64'd1 << SH_100) + 64'd99) / 64'd100);
  localparam logic [11:0] RCP_153 =
    12'(((64'd1 << SH_153) + MP_DIV - 64'd1) / MP_DIV);
  localparam logic [11:0] RCP_5 =
    12'(((64'd1 << SH_5) + MP_MUL - 64'd1) / MP_MUL);
  localparam logic [15:0] RCP_15 =
    16'(((64'd1 << SH_15) + 64'd14) / 64'd15);
  localparam logic [11:0] RCP_60 =
    12'(((64'd1 << SH_60) + MINS_PER_HOUR - 64'd1) / MINS_PER_HOUR);

endpackage
`default_nettype wire

// File: rtl/ecd_day_split.sv
`default_nettype none
module ecd_day_split import ecd_pkg::*; (
  input  logic                       clk,
  input  logic [SPLIT_STAGES-1:0]    ld,
  input  logic signed [EPOCH_W-1:0]  epoch,
  input  logic signed [OFFSET_W-1:0] offset,
  output logic [DAYS_W-1:0]          days,
  output logic [SOD_W-1:0]           sod
);

  localparam logic [20:0] DIV_W = 21'(SOD_ODD);

  logic signed [EPOCH_W-1:0] ep_r;
  logic [40:0] u_r;
  logic [41:0] sum;

  logic [20:0] x2, x4, x6;
  logic [43:0] p2, p4, p6;
  logic [43:0] p2_r, p4_r, p6_r;
  logic [20:0] x2_r, x4_r, x6_r;
  logic [10:0] q3, q5, q7;
  logic [20:0] t3, t5, t7;

  logic [21:0] lo2_r, lo3_r;
  logic [10:0] lo4_r, lo5_r;
  logic [SOD_SH-1:0] sub2_r, sub3_r, sub4_r, sub5_r, sub6_r;
  logic [9:0]  r3_r, r5_r;
  logic [1:0]  qh3_r, qh4_r, qh5_r, qh6_r;
  logic [10:0] qm5_r, qm6_r;
  logic [DAYS_W-1:0] days_r;
  logic [SOD_W-1:0]  sod_r;

  assign sum = 42'(ep_r) + 42'(offset) + 42'(SEC_BIAS);

  // long division of u >> 7 by 675, 12 + 11 + 11 bits
  assign x2 = 21'(u_r[40:29]);
  assign p2 = x2 * RCP_675;
  assign q3 = p2_r[SH_675 +: 11];
  assign t3 = x2_r - 21'(q3) * DIV_W;

  assign x4 = {r3_r, lo3_r[21:11]};
  assign p4 = x4 * RCP_675;
  assign q5 = p4_r[SH_675 +: 11];
  assign t5 = x4_r - 21'(q5) * DIV_W;

  assign x6 = {r5_r, lo5_r};
  assign p6 = x6 * RCP_675;
  assign q7 = p6_r[SH_675 +: 11];
  assign t7 = x6_r - 21'(q7) * DIV_W;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ep_r <= epoch;
    end
    if (ld[1]) begin
      u_r <= sum[40:0];
    end
    if (ld[2]) begin
      x2_r   <= x2;
      p2_r   <= p2;
      lo2_r  <= u_r[28:7];
      sub2_r <= u_r[SOD_SH-1:0];
    end
    if (ld[3]) begin
      qh3_r  <= q3[1:0];
      r3_r   <= t3[9:0];
      lo3_r  <= lo2_r;
      sub3_r <= sub2_r;
    end
    if (ld[4]) begin
      x4_r   <= x4;
      p4_r   <= p4;
      lo4_r  <= lo3_r[10:0];
      qh4_r  <= qh3_r;
      sub4_r <= sub3_r;
    end
    if (ld[5]) begin
      qm5_r  <= q5;
      r5_r   <= t5[9:0];
      lo5_r  <= lo4_r;
      qh5_r  <= qh4_r;
      sub5_r <= sub4_r;
    end
    if (ld[6]) begin
      x6_r   <= x6;
      p6_r   <= p6;
      qh6_r  <= qh5_r;
      qm6_r  <= qm5_r;
      sub6_r <= sub5_r;
    end
    if (ld[7]) begin
      days_r <= {qh6_r, qm6_r, q7};
      sod_r  <= {t7[9:0], sub6_r};
    end
  end

  assign days = days_r;
  assign sod  = sod_r;

endmodule
`default_nettype wire

// File: rtl/ecd_civil.sv
`default_nettype none
module ecd_civil import ecd_pkg::*; (
  input  logic                     clk,
  input  logic [CONV_STAGES-1:0]   ld,
  input  logic [DAYS_W-1:0]        days,
  output logic signed [YEAR_W-1:0] year,
  output logic [MONTH_W-1:0]       month,
  output logic [DAY_W-1:0]         day,
  output logic [WDAY_W-1:0]        weekday
);

  localparam logic [3:0] MP_WRAP   = 4'd10;
  localparam logic [3:0] MAR_SHIFT = 4'd3;
  localparam logic [3:0] MP_BACK   = 4'd9;
  localparam logic [3:0] FEB       = 4'd2;

  typedef struct packed {
    logic [DAYS_W-1:0] dd;
    logic [WDAY_W-1:0] wd;
    logic [6:0]        era;
    logic [17:0]       doe;
    logic [17:0]       n;
    logic [8:0]        yoe;
    logic [8:0]        doy;
    logic [3:0]        mon;
    logic [10:0]       x5;
  } civ_t;

  function automatic logic [WDAY_W-1:0] mod7(input logic [DAYS_W:0] x);
    logic [26:0] xp;
    logic [5:0]  s;
    logic [3:0]  f;
    logic [3:0]  g;
    xp = 27'(x);
    s  = '0;
    for (int i = 0; i < 9; i++) begin
      s = s + 6'(xp[3*i +: 3]);
    end
    f = 4'(s[5:3]) + 4'(s[2:0]);
    g = (f >= 4'd7) ? f - 4'd7 : f;
    return (g == 4'd7) ? 3'd0 : g[2:0];
  endfunction

  civ_t civ_r [CONV_STAGES-1];
  civ_t civ1_nxt, civ3_nxt, civ5_nxt, civ6_nxt, civ8_nxt;

  logic [48:0] pe, pe_r;
  logic [36:0] p1460, p1460_r, p36524, p36524_r, p365, p365_r;
  logic [18:0] p100, p100_r;
  logic [22:0] pmp, pmp_r, p5, p5_r;
  logic [23:0] doe_full;
  logic [17:0] n_full, doy_full;
  logic [8:0]  yoe;
  logic [10:0] x153, x5;
  logic [3:0]  mp, mon;
  logic [8:0]  day_full;
  logic [15:0] yr;
  logic        jan_feb;

  logic signed [YEAR_W-1:0] year_r;
  logic [MONTH_W-1:0]       month_r;
  logic [DAY_W-1:0]         day_r;
  logic [WDAY_W-1:0]        weekday_r;

  assign pe       = days * RCP_ERA;
  assign doe_full = civ_r[0].dd - 24'(pe_r[SH_ERA +: 7]) * 24'(ERA_DAYS);

  assign p1460  = civ_r[1].doe * RCP_1460;
  assign p36524 = civ_r[1].doe * RCP_36524;
  assign n_full = civ_r[2].doe - 18'(p1460_r[SH_1460 +: 7])
                + 18'(p36524_r[SH_36524 +: 3])
                - 18'(civ_r[2].doe == 18'(ERA_DAYS - 64'd1));

  assign p365 = civ_r[3].n * RCP_365;
  assign yoe  = p365_r[SH_365 +: 9];
  assign p100 = yoe * RCP_100;

  assign doy_full = civ_r[5].doe - (18'(civ_r[5].yoe) * 18'(DAYS_PER_YEAR)
                  + 18'(civ_r[5].yoe[8:2]) - 18'(p100_r[SH_100 +: 2]));

  assign x153 = 11'(civ_r[6].doy) * 11'(MP_MUL) + 11'(MP_ADD);
  assign pmp  = x153 * RCP_153;

  assign mp  = pmp_r[SH_153 +: 4];
  assign mon = (mp < MP_WRAP) ? mp + MAR_SHIFT : mp - MP_BACK;
  assign x5  = 11'(mp) * 11'(MP_DIV) + 11'(MP_ADD);

  assign p5 = civ_r[8].x5 * RCP_5;

  assign day_full = civ_r[9].doy - 9'(p5_r[SH_5 +: 9]) + 9'd1;
  assign jan_feb  = (civ_r[9].mon <= FEB);
  assign yr       = 16'(civ_r[9].yoe) + 16'(civ_r[9].era) * 16'(YEARS_PER_ERA)
                  + 16'(jan_feb) - 16'(YEAR_BIAS);

  always_comb begin
    civ1_nxt     = civ_r[0];
    civ1_nxt.era = pe_r[SH_ERA +: 7];
    civ1_nxt.doe = doe_full[17:0];
    civ3_nxt     = civ_r[2];
    civ3_nxt.n   = n_full;
    civ5_nxt     = civ_r[4];
    civ5_nxt.yoe = yoe;
    civ6_nxt     = civ_r[5];
    civ6_nxt.doy = doy_full[8:0];
    civ8_nxt     = civ_r[7];
    civ8_nxt.mon = mon;
    civ8_nxt.x5  = x5;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      civ_r[0] <= '{dd: days, wd: mod7(25'(days) + 25'(WDAY_SHIFT)), default: '0};
      pe_r     <= pe;
    end
    if (ld[1]) begin
      civ_r[1] <= civ1_nxt;
    end
    if (ld[2]) begin
      civ_r[2] <= civ_r[1];
      p1460_r  <= p1460;
      p36524_r <= p36524;
    end
    if (ld[3]) begin
      civ_r[3] <= civ3_nxt;
    end
    if (ld[4]) begin
      civ_r[4] <= civ_r[3];
      p365_r   <= p365;
    end
    if (ld[5]) begin
      civ_r[5] <= civ5_nxt;
      p100_r   <= p100;
    end
    if (ld[6]) begin
      civ_r[6] <= civ6_nxt;
    end
    if (ld[7]) begin
      civ_r[7] <= civ_r[6];
      pmp_r    <= pmp;
    end
    if (ld[8]) begin
      civ_r[8] <= civ8_nxt;
    end
    if (ld[9]) begin
      civ_r[9] <= civ_r[8];
      p5_r     <= p5;
    end
    if (ld[10]) begin
      year_r    <= $signed(yr);
      month_r   <= civ_r[9].mon;
      day_r     <= day_full[4:0];
      weekday_r <= civ_r[9].wd;
    end
  end

  assign year    = year_r;
  assign month   = month_r;
  assign day     = day_r;
  assign weekday = weekday_r;

endmodule
`default_nettype wire

// File: rtl/ecd_tod.sv
`default_nettype none
module ecd_tod import ecd_pkg::*; (
  input  logic                   clk,
  input  logic [CONV_STAGES-1:0] ld,
  input  logic [SOD_W-1:0]       sod,
  output logic [HOUR_W-1:0]      hour,
  output logic [MINUTE_W-1:0]    minute
);

  localparam int unsigned HM_DEPTH = CONV_STAGES - 2;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } hm_t;

  logic [30:0] p15, p15_r;
  logic [10:0] tm, tm_r;
  logic [22:0] p60, p60_r;
  logic [HOUR_W-1:0] hr;
  logic [10:0] min_full;
  hm_t hm_r [HM_DEPTH];

  // minutes of day = (sod >> 2) / 15
  assign p15      = sod[SOD_W-1:2] * RCP_15;
  assign tm       = p15_r[SH_15 +: 11];
  assign p60      = tm * RCP_60;
  assign hr       = p60_r[SH_60 +: HOUR_W];
  assign min_full = tm_r - 11'(hr) * 11'(MINS_PER_HOUR);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p15_r <= p15;
    end
    if (ld[1]) begin
      tm_r  <= tm;
      p60_r <= p60;
    end
    if (ld[2]) begin
      hm_r[0] <= '{hour: hr, minute: min_full[MINUTE_W-1:0]};
    end
    for (int k = 1; k < HM_DEPTH; k++) begin
      if (ld[k+2]) begin
        hm_r[k] <= hm_r[k-1];
      end
    end
  end

  assign hour   = hm_r[HM_DEPTH-1].hour;
  assign minute = hm_r[HM_DEPTH-1].minute;

endmodule
`default_nettype wire

// File: rtl/epoch_seconds_to_civil_date.sv
// Converts signed epoch seconds plus a programmable UTC offset into local
// proleptic Gregorian year, month, day, hour, minute and weekday (0 = Sunday).
// Fully pipelined: one beat is taken every cycle while in_stall is low,
// and results leave in order. The depth is set by the chain of constant
// divisions (three 11/12-bit long-division steps by 675 for the day split,
// then the era, year-of-era, day-of-year, month and day steps), each done
// as a reciprocal multiply with its own register. A stage only holds while
// the output is stalled and it and every stage ahead hold a valid beat, so
// in_stall rises only when the output is stalled and the pipeline is full.
// The offset register resets to zero; the user must write it with cfg_wr_en
// only while the block is empty, as the block itself does not enforce this.
`default_nettype none
module epoch_seconds_to_civil_date import ecd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [EPOCH_W-1:0]  in_epoch_seconds,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [YEAR_W-1:0]   out_year_out,
  output logic [MONTH_W-1:0]         out_month_out,
  output logic [DAY_W-1:0]           out_day_out,
  output logic [HOUR_W-1:0]          out_hour_out,
  output logic [MINUTE_W-1:0]        out_minute_out,
  output logic [WDAY_W-1:0]          out_weekday_out,
  input  logic                       cfg_wr_en,
  input  logic signed [OFFSET_W-1:0] cfg_wr_data
);

  logic signed [OFFSET_W-1:0] offset_r;
  logic [NUM_STAGES-1:0] vld_r, vld_nxt, ld;
  logic [DAYS_W-1:0] days;
  logic [SOD_W-1:0]  sod;

  // a stage loads when some stage at or after it is empty, or the output moves
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_ld
    assign ld[g] = !out_stall || !(&vld_r[NUM_STAGES-1:g]);
  end

  assign vld_nxt = ({vld_r[NUM_STAGES-2:0], in_valid} & ld) | (vld_r & ~ld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      offset_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  ecd_day_split u_split (
    .clk    (clk),
    .ld     (ld[SPLIT_STAGES-1:0]),
    .epoch  (in_epoch_seconds),
    .offset (offset_r),
    .days   (days),
    .sod    (sod)
  );

  ecd_civil u_civil (
    .clk     (clk),
    .ld      (ld[NUM_STAGES-1:SPLIT_STAGES]),
    .days    (days),
    .year    (out_year_out),
    .month   (out_month_out),
    .day     (out_day_out),
    .weekday (out_weekday_out)
  );

  ecd_tod u_tod (
    .clk    (clk),
    .ld     (ld[NUM_STAGES-1:SPLIT_STAGES]),
    .sod    (sod),
    .hour   (out_hour_out),
    .minute (out_minute_out)
  );

endmodule
`default_nettype wire

// File: rtl/ecd_checker.sv
`default_nettype none
module ecd_checker import ecd_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [YEAR_W-1:0]   out_year_out,
  input logic [MONTH_W-1:0]         out_month_out,
  input logic [DAY_W-1:0]           out_day_out,
  input logic [HOUR_W-1:0]          out_hour_out,
  input logic [MINUTE_W-1:0]        out_minute_out,
  input logic [WDAY_W-1:0]          out_weekday_out
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year_out)
      && $stable(out_month_out) && $stable(out_day_out) && $stable(out_hour_out)
      && $stable(out_minute_out) && $stable(out_weekday_out))
    else $error("result beat changed while stalled");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // input only backs up behind a stalled full pipeline
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in pipeline");

  // fields of a result beat stay in range
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_out >= 4'd1 && out_month_out <= 4'd12
      && out_day_out >= 5'd1 && out_day_out <= 5'd31 && out_hour_out <= 5'd23
      && out_minute_out <= 6'd59 && out_weekday_out <= 3'd6)
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_civil_date ecd_checker u_ecd_checker (.*);
`default_nettype wire

// File: dv/civil_date_checker.sv
module civil_date_checker import ecd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [EPOCH_W-1:0]  in_epoch_seconds,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [YEAR_W-1:0]   out_year_out,
  input  logic [MONTH_W-1:0]         out_month_out,
  input  logic [DAY_W-1:0]           out_day_out,
  input  logic [HOUR_W-1:0]          out_hour_out,
  input  logic [MINUTE_W-1:0]        out_minute_out,
  input  logic [WDAY_W-1:0]          out_weekday_out,
  input  logic                       cfg_wr_en,
  input  logic signed [OFFSET_W-1:0] cfg_wr_data,
  output int                         mismatch_count,
  output int                         dates_pending,
  output int                         dates_checked
);

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
    logic [HOUR_W-1:0]        hour;
    logic [MINUTE_W-1:0]      minute;
    logic [WDAY_W-1:0]        weekday;
  } civil_t;

  civil_t                     expected_dates[$];
  logic signed [OFFSET_W-1:0] local_offset;

  function automatic civil_t civil_of(input logic signed [EPOCH_W-1:0] epoch,
                                      input logic signed [OFFSET_W-1:0] offset);
    longint secs, days, sod, wd, z, era, doe, yoe, doy, mp, mon, yr;
    civil_t c;
    secs = longint'(epoch) + longint'(offset);
    // floor split: negative times fall on the earlier day
    days = (secs >= 0 ? secs : secs - (longint'(SECS_PER_DAY) - 1))
         / longint'(SECS_PER_DAY);
    sod  = secs - days * longint'(SECS_PER_DAY);
    wd   = (days + 4) % 7;
    if (wd < 0) wd += 7;
    z    = days + longint'(SHIFT_TO_ERA0);
    era  = (z >= 0 ? z : z - (longint'(ERA_DAYS) - 1)) / longint'(ERA_DAYS);
    doe  = z - era * longint'(ERA_DAYS);
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    c.year    = YEAR_W'(yr);
    c.month   = MONTH_W'(mon);
    c.day     = DAY_W'(doy - (153 * mp + 2) / 5 + 1);
    c.hour    = HOUR_W'(sod / 3600);
    c.minute  = MINUTE_W'((sod % 3600) / 60);
    c.weekday = WDAY_W'(wd);
    return c;
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    civil_t want;
    if (!rst_n) begin
      local_offset = '0;
      expected_dates.delete();
      mismatch_count = 0;
      dates_pending = 0;
      dates_checked = 0;
    end else begin
      if (cfg_wr_en) local_offset = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result beat, expected none, actual %0d-%0d-%0d",
                   $time, out_year_out, out_month_out, out_day_out);
        end else begin
          want = expected_dates.pop_front();
          compare_field("year", $signed(want.year), out_year_out);
          compare_field("month", want.month, out_month_out);
          compare_field("day", want.day, out_day_out);
          compare_field("hour", want.hour, out_hour_out);
          compare_field("minute", want.minute, out_minute_out);
          compare_field("weekday", want.weekday, out_weekday_out);
          dates_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_dates.push_back(civil_of(in_epoch_seconds, local_offset));
      end
      dates_pending = expected_dates.size();
    end
  end

endmodule

// File: dv/testbench.sv
module testbench import ecd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 9;
  localparam int RANDOM_PER_PHASE = 67;
  localparam int DRAIN_CYCLES = 30;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [EPOCH_W-1:0]  in_epoch_seconds = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [YEAR_W-1:0]   out_year_out;
  logic [MONTH_W-1:0]         out_month_out;
  logic [DAY_W-1:0]           out_day_out;
  logic [HOUR_W-1:0]          out_hour_out;
  logic [MINUTE_W-1:0]        out_minute_out;
  logic [WDAY_W-1:0]          out_weekday_out;
  logic                       cfg_wr_en = 1'b0;
  logic signed [OFFSET_W-1:0] cfg_wr_data = '0;

  int mismatch_count;
  int dates_pending;
  int dates_checked;
  int times_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;

  // leap days, century rules, era starts, epoch extremes, bit patterns
  longint directed_times [23] = '{
    0, -1, 1, 86399, 86400, -86400, -86401,
    64'sd549755813887, -64'sd549755813888,
    68169600, 68256000, 951782400, 951868800,
    -64'sd2203891200, -64'sd2203977600,
    -64'sd62162035200, -64'sd62162035201, -64'sd74784816000,
    64'sd366503875925, -64'sd366503875926,
    2147483647, 64'sd2147483648, 1704067199
  };

  always #1 clk = ~clk;

  epoch_seconds_to_civil_date uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_hour_out     (out_hour_out),
    .out_minute_out   (out_minute_out),
    .out_weekday_out  (out_weekday_out),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  civil_date_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_hour_out     (out_hour_out),
    .out_minute_out   (out_minute_out),
    .out_weekday_out  (out_weekday_out),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .dates_pending    (dates_pending),
    .dates_checked    (dates_checked)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_time(input logic signed [EPOCH_W-1:0] secs);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    times_sent++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dates_pending != 0) @(negedge clk);
  endtask

  task automatic write_offset(input int offset);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= OFFSET_W'(offset);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [EPOCH_W-1:0] pick_time();
    longint t;
    case ($urandom_range(0, 4))
      0: t = longint'({$urandom(), $urandom()});
      1: t = $urandom_range(0, 1)
             ? 64'sd549755813887 - longint'($urandom_range(0, 200000))
             : -64'sd549755813888 + longint'($urandom_range(0, 200000));
      2: t = (longint'($urandom_range(0, 12600000)) - 6300000) * 86400
             + longint'($urandom_range(0, 120)) - 60;
      3: t = ((longint'($urandom_range(0, 84)) - 37) * 146097 - 719468) * 86400
             + longint'($urandom_range(0, 200000)) - 100000;
      default: t = longint'($signed($urandom()));
    endcase
    return EPOCH_W'(t);
  endfunction

  initial begin : stimulus
    int next_offset;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin
          tx_idle_pct = 31;
          rx_idle_pct = 62;
        end
        1: begin
          tx_idle_pct = 62;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (phase)
        1: next_offset = 50400;
        2: next_offset = -65536;
        4: next_offset = 65535;
        5: next_offset = -50400;
        7: next_offset = -1;
        default: next_offset = int'($urandom_range(0, 100800)) - 50400;
      endcase
      if (phase != 0) write_offset(next_offset);
      if (phase == 0 || phase == 4) begin
        foreach (directed_times[i]) send_time(EPOCH_W'(directed_times[i]));
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) wait_for_drain();
        send_time(pick_time());
      end
      wait_for_drain();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d timestamps under %0d offset settings, %0d dates checked,",
             times_sent, PHASES, dates_checked);
    $display("with sender and receiver stalls in both proportions and a full-rate stretch.");
    if (mismatch_count == 0 && dates_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ecd_pkg.sv
rtl/ecd_day_split.sv
rtl/ecd_civil.sv
rtl/ecd_tod.sv
rtl/epoch_seconds_to_civil_date.sv
rtl/ecd_checker.sv
dv/civil_date_checker.sv
dv/testbench.sv
